### hdl/cursor_linked_list_engine_macros.svh
// Assertion macros shared by the cursor linked-list engine.
// No dependencies; include with the bare file name.
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define CLLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/clle_pkg.sv
`timescale 1ns / 1ps
// Types and codes of the cursor linked-list engine.
// No dependencies; used by the top level.
package clle_pkg;

   localparam logic [2:0] FUNC_INIT       = 3'd0;
   localparam logic [2:0] FUNC_NEW_HEADER = 3'd1;
   localparam logic [2:0] FUNC_READ_CELL  = 3'd2;
   localparam logic [2:0] FUNC_FIND       = 3'd3;
   localparam logic [2:0] FUNC_DELETE     = 3'd4;
   localparam logic [2:0] FUNC_INSERT     = 3'd5;
   localparam logic [2:0] FUNC_CLEAR      = 3'd6;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] element_value;
      logic [7:0]         cell_position;
      logic [7:0]         list_header;
   } clle_req_type;

   typedef struct packed {
      logic [7:0]         result_position;
      logic signed [31:0] result_element;
      logic               last_flag;
      logic               status;
   } clle_rsp_type;

   typedef enum logic [21:0] {
      ST_IDLE  = 22'h000001,
      ST_SWEEP = 22'h000002,
      ST_NH_T  = 22'h000004,
      ST_NH_N  = 22'h000008,
      ST_NH_Z  = 22'h000010,
      ST_RC    = 22'h000020,
      ST_FD_H  = 22'h000040,
      ST_FD_W  = 22'h000080,
      ST_DL_H  = 22'h000100,
      ST_DL_W  = 22'h000200,
      ST_DL_U1 = 22'h000400,
      ST_DL_U2 = 22'h000800,
      ST_DL_U3 = 22'h001000,
      ST_IN_T  = 22'h002000,
      ST_IN_N  = 22'h004000,
      ST_IN_P  = 22'h008000,
      ST_IN_L  = 22'h010000,
      ST_CL_F  = 22'h020000,
      ST_CL_H  = 22'h040000,
      ST_CL_W  = 22'h080000,
      ST_CL_E0 = 22'h100000,
      ST_CL_E1 = 22'h200000
   } clle_state_type;

endpackage

### hdl/clle_cell_store.sv
`timescale 1ns / 1ps
// Cell store: link memory and element memory, one write port each and a shared
// registered read port with write-to-read forwarding. No dependencies.
module clle_cell_store #(
   parameter int CELL_COUNT   = 256,
   parameter int ELEMENT_BITS = 32,
   localparam int CW = $clog2(CELL_COUNT)
) (
   input  logic                    clock,
   input  logic                    link_we,
   input  logic [CW-1:0]           link_wa,
   input  logic [CW-1:0]           link_wd,
   input  logic                    elem_we,
   input  logic [CW-1:0]           elem_wa,
   input  logic [ELEMENT_BITS-1:0] elem_wd,
   input  logic                    rd_en,
   input  logic [CW-1:0]           rd_addr,
   output logic [CW-1:0]           link_q,
   output logic [ELEMENT_BITS-1:0] elem_q
);

   logic [CW-1:0]           links [CELL_COUNT];
   logic [ELEMENT_BITS-1:0] elems [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (link_we) begin
         links[link_wa] <= link_wd;
      end
      if (elem_we) begin
         elems[elem_wa] <= elem_wd;
      end
   end

   // forward a same-cycle write to the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         link_q <= (link_we && (link_wa == rd_addr)) ? link_wd : links[rd_addr];
         elem_q <= (elem_we && (elem_wa == rd_addr)) ? elem_wd : elems[rd_addr];
      end
   end

endmodule

### hdl/cursor_linked_list_engine.sv
`timescale 1ns / 1ps
// Cursor linked-list engine: cell store with free chain headed by cell 0.
// Depends on clle_pkg, clle_cell_store and the assertion macro header.
//
// Usage:
//   Command channel: drive req_item and raise start; the item is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the operation finishes.
//   Result channel: exactly one result per item, shown on rsp_item for one
//   cycle with rsp_valid high. The receiver cannot stall; it must take the
//   result in that cycle. The next item may be taken in that same cycle.
//   The time to a result of find, delete and delete list grows with the
//   number of cells walked.
//   Find, delete and delete list follow one link per cycle through the
//   single read port of the link memory; each cycle of the other operations
//   is at most one read and one write of that memory.
//   Reset: after reset is released the block rebuilds the free chain, one
//   cell per cycle, with busy high; no result is given.
module cursor_linked_list_engine
   import clle_pkg::*;
#(
   parameter int CELL_COUNT   = 256,
   parameter int ELEMENT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  clle_req_type req_item,
   output logic         rsp_valid,
   output clle_rsp_type rsp_item
);

`include "cursor_linked_list_engine_macros.svh"

   localparam int CW = $clog2(CELL_COUNT);
   localparam int SW = $clog2(CELL_COUNT + 1);
   localparam int EB = ELEMENT_BITS;
   localparam logic [CW-1:0] LAST_CELL = CW'(CELL_COUNT - 1);
   localparam logic [SW-1:0] WALK_LIMIT = SW'(CELL_COUNT);

   clle_state_type state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           init_rsp_ff, init_rsp_in;
   logic [EB-1:0]  x_ff, x_in;
   logic [CW-1:0]  pos_ff, pos_in, hdr_ff, hdr_in;
   logic [CW-1:0]  p_ff, p_in, t_ff, t_in, n_ff, n_in, fh_ff, fh_in;
   logic [SW-1:0]  steps_ff, steps_in, steps_inc;
   logic           rsp_valid_ff, rsp_fire;
   clle_rsp_type   rsp_ff, rsp_in;

   logic          link_we, elem_we, rd_en;
   logic [CW-1:0] link_wa, link_wd, elem_wa, rd_addr, link_q;
   logic [EB-1:0] elem_wd, elem_q;

   logic [CW-1:0] cell_mod [256];
   logic [CW-1:0] pos_mod, hdr_mod;

   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign cell_mod[g] = CW'(g % CELL_COUNT);
   end

   assign pos_mod   = cell_mod[req_item.cell_position];
   assign hdr_mod   = cell_mod[req_item.list_header];
   assign steps_inc = steps_ff + SW'(1);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   clle_cell_store #(
      .CELL_COUNT  (CELL_COUNT),
      .ELEMENT_BITS(ELEMENT_BITS)
   ) u_store (
      .clock  (clock),
      .link_we(link_we),
      .link_wa(link_wa),
      .link_wd(link_wd),
      .elem_we(elem_we),
      .elem_wa(elem_wa),
      .elem_wd(elem_wd),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .link_q (link_q),
      .elem_q (elem_q)
   );

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      init_rsp_in = init_rsp_ff;
      x_in        = x_ff;
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      p_in        = p_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      fh_in       = fh_ff;
      steps_in    = steps_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      link_we     = 1'b0;
      link_wa     = '0;
      link_wd     = '0;
      elem_we     = 1'b0;
      elem_wa     = t_ff;
      elem_wd     = x_ff;
      rsp_fire    = 1'b0;
      rsp_in      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in   = EB'($unsigned(req_item.element_value));
               pos_in = pos_mod;
               hdr_in = hdr_mod;
               unique case (req_item.func)
                  FUNC_INIT: begin
                     idx_in      = '0;
                     init_rsp_in = 1'b1;
                     state_in    = ST_SWEEP;
                  end
                  FUNC_NEW_HEADER: begin
                     rd_en    = 1'b1;
                     state_in = ST_NH_T;
                  end
                  FUNC_READ_CELL: begin
                     rd_en    = 1'b1;
                     rd_addr  = pos_mod;
                     state_in = ST_RC;
                  end
                  FUNC_FIND: begin
                     rd_en    = 1'b1;
                     rd_addr  = hdr_mod;
                     state_in = ST_FD_H;
                  end
                  FUNC_DELETE: begin
                     rd_en    = 1'b1;
                     rd_addr  = hdr_mod;
                     state_in = ST_DL_H;
                  end
                  FUNC_INSERT: begin
                     rd_en    = 1'b1;
                     state_in = ST_IN_T;
                  end
                  FUNC_CLEAR: begin
                     rd_en    = 1'b1;
                     state_in = ST_CL_F;
                  end
                  default: begin
                     rsp_fire = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            link_we = 1'b1;
            link_wa = idx_ff;
            link_wd = (idx_ff == LAST_CELL) ? '0 : idx_ff + CW'(1);
            if (idx_ff == LAST_CELL) begin
               state_in    = ST_IDLE;
               rsp_fire    = init_rsp_ff;
               init_rsp_in = 1'b0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_NH_T: begin
            if (link_q == '0) begin
               rsp_in.status = STATUS_FULL;
               rsp_fire      = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               t_in     = link_q;
               rd_en    = 1'b1;
               rd_addr  = link_q;
               state_in = ST_NH_N;
            end
         end
         ST_NH_N: begin
            link_we  = 1'b1;
            link_wd  = link_q;
            state_in = ST_NH_Z;
         end
         ST_NH_Z: begin
            link_we                = 1'b1;
            link_wa                = t_ff;
            rsp_in.result_position = 8'(t_ff);
            rsp_fire               = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_RC: begin
            rsp_in.result_position = 8'(link_q);
            rsp_in.result_element  = 32'(elem_q);
            rsp_in.last_flag       = (link_q == '0);
            rsp_fire               = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_FD_H: begin
            if (link_q == '0) begin
               rsp_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               p_in     = link_q;
               steps_in = '0;
               rd_en    = 1'b1;
               rd_addr  = link_q;
               state_in = ST_FD_W;
            end
         end
         ST_FD_W: begin
            if (elem_q == x_ff) begin
               rsp_in.result_position = 8'(p_ff);
               rsp_fire               = 1'b1;
               state_in               = ST_IDLE;
            end else if ((link_q == '0) || (steps_inc == WALK_LIMIT)) begin
               rsp_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               p_in     = link_q;
               steps_in = steps_inc;
               rd_en    = 1'b1;
               rd_addr  = link_q;
            end
         end
         ST_DL_H: begin
            if (link_q == '0) begin
               rsp_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               p_in     = hdr_ff;
               t_in     = link_q;
               steps_in = '0;
               rd_en    = 1'b1;
               rd_addr  = link_q;
               state_in = ST_DL_W;
            end
         end
         ST_DL_W: begin
            if (elem_q == x_ff) begin
               n_in     = link_q;
               state_in = ST_DL_U1;
            end else if ((link_q == '0) || (steps_inc == WALK_LIMIT)) begin
               rsp_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               p_in     = t_ff;
               t_in     = link_q;
               steps_in = steps_inc;
               rd_en    = 1'b1;
               rd_addr  = link_q;
            end
         end
         ST_DL_U1: begin
            link_we  = 1'b1;
            link_wa  = p_ff;
            link_wd  = n_ff;
            rd_en    = 1'b1;
            state_in = ST_DL_U2;
         end
         ST_DL_U2: begin
            link_we  = 1'b1;
            link_wa  = t_ff;
            link_wd  = link_q;
            state_in = ST_DL_U3;
         end
         ST_DL_U3: begin
            link_we  = 1'b1;
            link_wd  = t_ff;
            rsp_fire = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IN_T: begin
            if (link_q == '0) begin
               rsp_in.status = STATUS_FULL;
               rsp_fire      = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               t_in     = link_q;
               rd_en    = 1'b1;
               rd_addr  = link_q;
               state_in = ST_IN_N;
            end
         end
         ST_IN_N: begin
            link_we  = 1'b1;
            link_wd  = link_q;
            elem_we  = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            state_in = ST_IN_P;
         end
         ST_IN_P: begin
            link_we  = 1'b1;
            link_wa  = t_ff;
            link_wd  = link_q;
            state_in = ST_IN_L;
         end
         ST_IN_L: begin
            link_we                = 1'b1;
            link_wa                = pos_ff;
            link_wd                = t_ff;
            rsp_in.result_position = 8'(t_ff);
            rsp_fire               = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_CL_F: begin
            fh_in    = link_q;
            rd_en    = 1'b1;
            rd_addr  = hdr_ff;
            state_in = ST_CL_H;
         end
         ST_CL_H: begin
            steps_in = '0;
            if (link_q == '0) begin
               state_in = ST_CL_E0;
            end else begin
               p_in     = link_q;
               rd_en    = 1'b1;
               rd_addr  = link_q;
               state_in = ST_CL_W;
            end
         end
         ST_CL_W: begin
            link_we  = 1'b1;
            link_wa  = p_ff;
            link_wd  = fh_ff;
            fh_in    = p_ff;
            steps_in = steps_inc;
            if ((link_q == '0) || (steps_inc == WALK_LIMIT)) begin
               steps_in = '0;
               state_in = ST_CL_E0;
            end else begin
               p_in    = link_q;
               rd_en   = 1'b1;
               rd_addr = link_q;
            end
         end
         ST_CL_E0: begin
            link_we  = 1'b1;
            link_wd  = fh_ff;
            state_in = ST_CL_E1;
         end
         ST_CL_E1: begin
            link_we  = 1'b1;
            link_wa  = hdr_ff;
            rsp_fire = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         idx_ff       <= '0;
         init_rsp_ff  <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_rsp_ff  <= init_rsp_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      pos_ff <= pos_in;
      hdr_ff <= hdr_in;
      p_ff   <= p_in;
      t_ff   <= t_in;
      n_ff   <= n_in;
      fh_ff  <= fh_in;
      if (rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `CLLE_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `CLLE_ASSERT_NEXT(a_accept_moves, clock, reset, start && !busy, busy || rsp_valid, "item lost")
   `CLLE_ASSERT_SAME(a_last_no_link, clock, reset, rsp_valid && rsp_item.last_flag, rsp_item.result_position == 8'd0, "last cell with link")
   `CLLE_ASSERT_SAME(a_full_no_cell, clock, reset, rsp_valid && rsp_item.status, rsp_item.result_position == 8'd0, "full with cell")
   `CLLE_ASSERT_SAME(a_walk_bound, clock, reset, busy, steps_ff < WALK_LIMIT, "walk past limit")

endmodule
